@@ rtl/gboc_pkg.sv @@
// Shared types, widths and codes of the block occupancy calculator.
package gboc_pkg;

    localparam int BX_W       = 11;
    localparam int BY_W       = 11;
    localparam int BZ_W       = 7;
    localparam int RPT_W      = 8;
    localparam int SMB_W      = 19;

    localparam int WS_W       = 7;
    localparam int MTS_W      = 13;
    localparam int MBS_W      = 7;
    localparam int RSM_W      = 19;
    localparam int SMSM_W     = 19;

    localparam int XY_W       = BX_W + BY_W;
    localparam int THR_W      = 29;
    localparam int WPB_W      = THR_W;
    localparam int MAXW_W     = MTS_W;
    localparam int SMEM_W     = SMB_W + 1;
    localparam int BLK_W      = 19;
    localparam int USED_W     = BLK_W + WPB_W;
    localparam int RW_W       = RPT_W + WS_W;
    localparam int FRAC_W     = 16;
    localparam int OCC_W      = FRAC_W + 1;
    localparam int ACT_W      = 7;
    localparam int LIM_W      = 2;
    localparam int OCC_LAT    = FRAC_W + 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [OCC_W-1:0] Q_ONE = OCC_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_WARP_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_THREADS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGS_PER_SM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMEM_PER_SM = 3'd4;

    localparam logic [WS_W-1:0]   RST_WARP_SIZE   = 7'd32;
    localparam logic [MTS_W-1:0]  RST_MAX_THREADS = 13'd2048;
    localparam logic [MBS_W-1:0]  RST_MAX_BLOCKS  = 7'd32;
    localparam logic [RSM_W-1:0]  RST_REGS_PER_SM = 19'd65536;
    localparam logic [SMSM_W-1:0] RST_SMEM_PER_SM = 19'd102400;

    localparam logic [LIM_W-1:0] LIM_WARPS = 2'd0;
    localparam logic [LIM_W-1:0] LIM_REGS  = 2'd1;
    localparam logic [LIM_W-1:0] LIM_SMEM  = 2'd2;
    localparam logic [LIM_W-1:0] LIM_CAP   = 2'd3;

    typedef struct packed {
        logic [BX_W-1:0]  block_dim_x;
        logic [BY_W-1:0]  block_dim_y;
        logic [BZ_W-1:0]  block_dim_z;
        logic [RPT_W-1:0] regs_per_thread;
        logic [SMB_W-1:0] static_smem_bytes;
        logic [SMB_W-1:0] dynamic_smem_bytes;
    } t_in_item;

    typedef struct packed {
        logic [ACT_W-1:0] resident_blocks;
        logic [OCC_W-1:0] warp_occ;
        logic [OCC_W-1:0] reg_occ;
        logic [OCC_W-1:0] smem_occ;
        logic [OCC_W-1:0] blockcap_occ;
        logic [OCC_W-1:0] overall_occ;
        logic [LIM_W-1:0] limiter;
    } t_out_item;

    typedef struct packed {
        logic one;
        logic zero;
    } t_occ_flags;

endpackage

@@ rtl/gboc_div.sv @@
// Pipelined restoring divider that resolves one quotient bit per stage.
module gboc_div #(
    parameter int N = 8,
    parameter int D = 8
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [D-1:0] i_rem,
    input  logic [N-1:0] i_dvd,
    input  logic [D-1:0] i_dsr,
    output logic [N-1:0] o_quo,
    output logic [D-1:0] o_rem
);

    logic [D-1:0] r_rem [N];
    logic [N-1:0] r_quo [N];
    logic [D-1:0] r_dsr [N-1];
    logic [N-1:0] r_dvd [N-1];

    logic [D-1:0] s_rem [N];
    logic [N-1:0] s_quo [N];
    logic [D-1:0] s_dsr [N];
    logic [N-1:0] s_dvd [N];

    logic [D-1:0] n_rem [N];
    logic [N-1:0] n_quo [N];

    assign s_rem[0] = i_rem;
    assign s_quo[0] = '0;
    assign s_dsr[0] = i_dsr;
    assign s_dvd[0] = i_dvd;

    for (genvar k = 1; k < N; k++) begin : g_link
        assign s_rem[k] = r_rem[k-1];
        assign s_quo[k] = r_quo[k-1];
        assign s_dsr[k] = r_dsr[k-1];
        assign s_dvd[k] = r_dvd[k-1];
    end

    always_comb begin
        logic [D:0] t;
        logic       ge;
        for (int k = 0; k < N; k++) begin
            t        = {s_rem[k], s_dvd[k][N-1]};
            ge       = (t >= {1'b0, s_dsr[k]});
            n_rem[k] = ge ? D'(t - {1'b0, s_dsr[k]}) : t[D-1:0];
            n_quo[k] = {s_quo[k][N-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
            for (int k = 0; k < N - 1; k++) begin
                r_dsr[k] <= s_dsr[k];
                r_dvd[k] <= {s_dvd[k][N-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_quo[N-1];
    assign o_rem = r_rem[N-1];

endmodule

@@ rtl/gboc_delay.sv @@
// Enabled shift line that keeps side data aligned with the divider stages.
module gboc_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_d = r_tap[DEPTH-1];

endmodule

@@ rtl/gboc_occ.sv @@
// Occupancy unit: warps used by a block count as a clamped Q1.16 fraction of the SM.
module gboc_occ (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [gboc_pkg::BLK_W-1:0]    i_blocks,
    input  logic [gboc_pkg::WPB_W-1:0]    i_wpb,
    input  logic [gboc_pkg::MAXW_W-1:0]   i_maxw,
    output logic [gboc_pkg::OCC_W-1:0]    o_occ
);
    import gboc_pkg::*;

    logic [USED_W-1:0] r_used;
    logic [MAXW_W-1:0] r_maxw1;
    logic              r_zero1;
    logic [MAXW_W-1:0] r_rem0;
    logic [MAXW_W-1:0] r_maxw2;
    t_occ_flags        r_flags2;
    logic [OCC_W-1:0]  r_occ;

    logic [FRAC_W-1:0] quo;
    t_occ_flags        flags_d;
    logic              n_one;

    assign n_one = (r_used >= USED_W'(r_maxw1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_used   <= USED_W'(i_blocks) * USED_W'(i_wpb);
            r_maxw1  <= i_maxw;
            r_zero1  <= (i_maxw == '0) || (i_wpb == '0);
            r_rem0   <= n_one ? '0 : r_used[MAXW_W-1:0];
            r_maxw2  <= r_maxw1;
            r_flags2 <= '{one: n_one, zero: r_zero1};
            if (flags_d.zero) begin
                r_occ <= '0;
            end else if (flags_d.one) begin
                r_occ <= Q_ONE;
            end else begin
                r_occ <= OCC_W'(quo);
            end
        end
    end

    gboc_div #(.N(FRAC_W), .D(MAXW_W)) u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_rem (r_rem0),
        .i_dvd ('0),
        .i_dsr (r_maxw2),
        .o_quo (quo),
        .o_rem ()
    );

    gboc_delay #(.W($bits(t_occ_flags)), .DEPTH(FRAC_W)) u_flags (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_flags2),
        .o_d   (flags_d)
    );

    assign o_occ = r_occ;

endmodule

@@ rtl/gpu_block_occupancy_calc.sv @@
// Top level of the block occupancy calculator pipeline.
// Each request on the input channel carries one launch shape; the block returns
// one result request with the resident block count, five Q1.16 occupancies
// and the limiting resource. SM limits come from the configuration channel,
// which is always ready and should only be written while no request is in flight.
// Throughput is one request per cycle while the receiver does not hold off i_ready,
// set by the fully pipelined dividers that resolve one quotient bit per stage; the
// latency from acceptance to o_valid is set by the chain of warps-per-block,
// register-limit and occupancy dividers that follow one another.
// Reset loads the default SM limits and empties the pipeline.
// When the receiver holds off i_ready with a result waiting, the whole pipeline
// freezes and o_ready drops until the result is taken; nothing is lost or repeated.
module gpu_block_occupancy_calc #(
    parameter int REG_GRANULE = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  gboc_pkg::t_in_item                i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output gboc_pkg::t_out_item               o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gboc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gboc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gboc_pkg::*;

    localparam int     LAT    = 74;
    localparam int     RW_MAX = (2**RPT_W - 1) * (2**WS_W - 1) + REG_GRANULE - 1;
    localparam int     U_W    = $clog2(RW_MAX + 1);
    localparam int     RS     = U_W + 11;
    localparam longint RM     = ((longint'(1) << RS) + REG_GRANULE - 1) / REG_GRANULE;
    localparam int     PROD_W = U_W + RS + 1;
    localparam int     GQ_W   = U_W + 11;
    localparam int     RPB_W  = U_W + WPB_W;

    logic [WS_W-1:0]   r_ws;
    logic [MTS_W-1:0]  r_mts;
    logic [MBS_W-1:0]  r_mbs;
    logic [RSM_W-1:0]  r_rsm;
    logic [SMSM_W-1:0] r_smsm;

    logic [LAT:1]      r_v;
    logic              w_en;

    logic [XY_W-1:0]   r1_xy;
    logic [BZ_W-1:0]   r1_z;
    logic [RW_W-1:0]   r1_rptws;
    logic [SMEM_W-1:0] r1_smem;
    logic [THR_W-1:0]  r2_thr;
    logic [U_W-1:0]    r2_u;
    logic [U_W-1:0]    r3_rq;
    logic [U_W-1:0]    r4_rpw;
    logic [WPB_W-1:0]  r32_wpb;
    logic [MAXW_W-1:0] r32_maxw;
    logic [U_W-1:0]    r32_rpw;
    logic [RPB_W-1:0]  r33_rpb;
    logic [BLK_W-1:0]  r53_blk [4];
    logic [WPB_W-1:0]  r53_wpb;
    logic [MAXW_W-1:0] r53_maxw;
    logic [BLK_W-1:0]  r54_blk [4];
    logic [BLK_W-1:0]  r54_act;
    logic [WPB_W-1:0]  r54_wpb;
    logic [MAXW_W-1:0] r54_maxw;
    t_out_item         r_out;

    logic [PROD_W-1:0] n_prod;
    logic [THR_W-1:0]  wpb_q;
    logic [WS_W-1:0]   wpb_r;
    logic [MAXW_W-1:0] maxw_q;
    logic [MAXW_W-1:0] maxw_d;
    logic [U_W-1:0]    rpw_d;
    logic [MAXW_W-1:0] warp_q;
    logic [MAXW_W-1:0] warp_d;
    logic [BLK_W-1:0]  reg_q;
    logic [BLK_W-1:0]  smem_q;
    logic [BLK_W-1:0]  smem_d;
    logic              rpb_nz_d;
    logic              smem_nz_d;
    logic [WPB_W+MAXW_W-1:0] wm_d;
    logic [WPB_W-1:0]  wpb_d;
    logic [MAXW_W-1:0] maxw2_d;
    logic [BLK_W-1:0]  n_act;
    logic [BLK_W-1:0]  act_d;
    logic [OCC_W-1:0]  occ [5];
    t_out_item         n_out;

    assign w_en        = !r_v[LAT] || i_ready;
    assign o_ready     = w_en;
    assign o_valid     = r_v[LAT];
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws   <= RST_WARP_SIZE;
            r_mts  <= RST_MAX_THREADS;
            r_mbs  <= RST_MAX_BLOCKS;
            r_rsm  <= RST_REGS_PER_SM;
            r_smsm <= RST_SMEM_PER_SM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WARP_SIZE:   r_ws   <= i_cfg_data[WS_W-1:0];
                CFG_MAX_THREADS: r_mts  <= i_cfg_data[MTS_W-1:0];
                CFG_MAX_BLOCKS:  r_mbs  <= i_cfg_data[MBS_W-1:0];
                CFG_REGS_PER_SM: r_rsm  <= i_cfg_data[RSM_W-1:0];
                CFG_SMEM_PER_SM: r_smsm <= i_cfg_data[SMSM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[LAT-1:1], i_valid};
        end
    end

    assign n_prod = PROD_W'(r2_u) * PROD_W'(RM);
    assign wpb_d   = wm_d[WPB_W+MAXW_W-1:MAXW_W];
    assign maxw2_d = wm_d[MAXW_W-1:0];

    always_comb begin
        n_act = r53_blk[0];
        if (r53_blk[1] < n_act) begin
            n_act = r53_blk[1];
        end
        if (r53_blk[3] < n_act) begin
            n_act = r53_blk[3];
        end
        if (r53_blk[2] < n_act) begin
            n_act = r53_blk[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_xy    <= XY_W'(i_data.block_dim_x) * XY_W'(i_data.block_dim_y);
            r1_z     <= i_data.block_dim_z;
            r1_rptws <= RW_W'(i_data.regs_per_thread) * RW_W'(r_ws);
            r1_smem  <= SMEM_W'(i_data.static_smem_bytes) + SMEM_W'(i_data.dynamic_smem_bytes);

            r2_thr   <= THR_W'(r1_xy) * THR_W'(r1_z);
            r2_u     <= U_W'(r1_rptws) + U_W'(REG_GRANULE - 1);
            r3_rq    <= U_W'(n_prod >> RS);
            r4_rpw   <= U_W'(GQ_W'(r3_rq) * GQ_W'(REG_GRANULE));

            r32_wpb  <= (r_ws == '0) ? '0 : wpb_q + WPB_W'(wpb_r != '0);
            r32_maxw <= (r_ws == '0) ? '0 : maxw_d;
            r32_rpw  <= rpw_d;
            r33_rpb  <= RPB_W'(r32_rpw) * RPB_W'(r32_wpb);

            r53_blk[0] <= (wpb_d != '0) ? BLK_W'(warp_d) : '0;
            r53_blk[1] <= rpb_nz_d ? reg_q
                        : ((wpb_d != '0) ? BLK_W'(warp_d) : '0);
            r53_blk[2] <= smem_nz_d ? smem_d
                        : ((wpb_d != '0) ? BLK_W'(warp_d) : '0);
            r53_blk[3] <= BLK_W'(r_mbs);
            r53_wpb    <= wpb_d;
            r53_maxw   <= maxw2_d;

            r54_blk    <= r53_blk;
            r54_act    <= n_act;
            r54_wpb    <= r53_wpb;
            r54_maxw   <= r53_maxw;

            r_out      <= n_out;
        end
    end

    gboc_div #(.N(THR_W), .D(WS_W)) u_wpb_div (
        .i_clk (i_clk), .i_en (w_en), .i_rem ('0),
        .i_dvd (r2_thr), .i_dsr (r_ws), .o_quo (wpb_q), .o_rem (wpb_r)
    );

    gboc_div #(.N(MTS_W), .D(WS_W)) u_maxw_div (
        .i_clk (i_clk), .i_en (w_en), .i_rem ('0),
        .i_dvd (r_mts), .i_dsr (r_ws), .o_quo (maxw_q), .o_rem ()
    );

    gboc_delay #(.W(MAXW_W), .DEPTH(16)) u_maxw_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (maxw_q), .o_d (maxw_d)
    );

    gboc_delay #(.W(U_W), .DEPTH(27)) u_rpw_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (r4_rpw), .o_d (rpw_d)
    );

    gboc_div #(.N(MAXW_W), .D(WPB_W)) u_warp_div (
        .i_clk (i_clk), .i_en (w_en), .i_rem ('0),
        .i_dvd (r32_maxw), .i_dsr (r32_wpb), .o_quo (warp_q), .o_rem ()
    );

    gboc_delay #(.W(MAXW_W), .DEPTH(7)) u_warp_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (warp_q), .o_d (warp_d)
    );

    gboc_div #(.N(BLK_W), .D(RPB_W)) u_reg_div (
        .i_clk (i_clk), .i_en (w_en), .i_rem ('0),
        .i_dvd (r_rsm), .i_dsr (r33_rpb), .o_quo (reg_q), .o_rem ()
    );

    gboc_delay #(.W(1), .DEPTH(19)) u_rpbnz_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (r33_rpb != '0), .o_d (rpb_nz_d)
    );

    gboc_delay #(.W(WPB_W + MAXW_W), .DEPTH(20)) u_wm_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d ({r32_wpb, r32_maxw}), .o_d (wm_d)
    );

    gboc_div #(.N(BLK_W), .D(SMEM_W)) u_smem_div (
        .i_clk (i_clk), .i_en (w_en), .i_rem ('0),
        .i_dvd (r_smsm), .i_dsr (r1_smem), .o_quo (smem_q), .o_rem ()
    );

    gboc_delay #(.W(BLK_W), .DEPTH(32)) u_smem_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (smem_q), .o_d (smem_d)
    );

    gboc_delay #(.W(1), .DEPTH(51)) u_smemnz_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (r1_smem != '0), .o_d (smem_nz_d)
    );

    for (genvar g = 0; g < 4; g++) begin : g_occ
        gboc_occ u_occ (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_blocks (r54_blk[g]),
            .i_wpb    (r54_wpb),
            .i_maxw   (r54_maxw),
            .o_occ    (occ[g])
        );
    end

    gboc_occ u_occ_all (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_blocks (r54_act),
        .i_wpb    (r54_wpb),
        .i_maxw   (r54_maxw),
        .o_occ    (occ[4])
    );

    gboc_delay #(.W(BLK_W), .DEPTH(OCC_LAT)) u_act_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (r54_act), .o_d (act_d)
    );

    always_comb begin
        logic [OCC_W-1:0] best;
        logic [LIM_W-1:0] lim;
        best = occ[0];
        lim  = LIM_WARPS;
        if (occ[1] < best) begin
            best = occ[1];
            lim  = LIM_REGS;
        end
        if (occ[2] < best) begin
            best = occ[2];
            lim  = LIM_SMEM;
        end
        if (occ[3] < best) begin
            lim  = LIM_CAP;
        end
        n_out.resident_blocks   = act_d[ACT_W-1:0];
        n_out.warp_occ          = occ[0];
        n_out.reg_occ           = occ[1];
        n_out.smem_occ          = occ[2];
        n_out.blockcap_occ      = occ[3];
        n_out.overall_occ       = occ[4];
        n_out.limiter           = lim;
    end

    a_overall_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.overall_occ <= o_data.warp_occ)
                 && (o_data.overall_occ <= o_data.reg_occ)
                 && (o_data.overall_occ <= o_data.smem_occ)
                 && (o_data.overall_occ <= o_data.blockcap_occ))
        else $error("overall occupancy exceeds a per-resource occupancy");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.warp_occ <= Q_ONE) && (o_data.reg_occ <= Q_ONE)
                 && (o_data.smem_occ <= Q_ONE) && (o_data.blockcap_occ <= Q_ONE))
        else $error("occupancy above one");

    a_lim_regs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.limiter == LIM_REGS) |-> (o_data.reg_occ < o_data.warp_occ))
        else $error("register limiter chosen without a strictly lower occupancy");

    a_lim_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.limiter == LIM_CAP)
            |-> (o_data.blockcap_occ < o_data.warp_occ)
             && (o_data.blockcap_occ < o_data.reg_occ)
             && (o_data.blockcap_occ < o_data.smem_occ))
        else $error("block cap limiter chosen without a strictly lower occupancy");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request accepted while the pipeline is stalled");

endmodule
